[rtl/core/caw_pkg.sv]
// Shared types, widths and codes of the cumulative acknowledgement engine.
package caw_pkg;

	localparam int WINDOW_DEF = 64;
	localparam int QDEPTH_DEF = 2;

	localparam int SEQ_W   = 20;
	localparam int DIG_W   = 48;
	localparam int TIME_W  = 32;
	localparam int RTT_W   = 32;
	localparam int OUT_W   = 3;
	localparam int DUP_W   = 8;
	localparam int FREED_W = 7;

	localparam int CFG_W     = 32;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_START_SEQ   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_INITIAL_RTT = 1'b1;

	localparam logic [RTT_W-1:0] RTT_RESET = 32'd25600;

	localparam logic [OUT_W-1:0] OUT_ADVANCED     = 3'd0;
	localparam logic [OUT_W-1:0] OUT_DUPLICATE    = 3'd1;
	localparam logic [OUT_W-1:0] OUT_LATE         = 3'd2;
	localparam logic [OUT_W-1:0] OUT_MALFORMED    = 3'd3;
	localparam logic [OUT_W-1:0] OUT_RECORDED     = 3'd4;
	localparam logic [OUT_W-1:0] OUT_SEND_OUTSIDE = 3'd5;

	localparam logic KIND_SEND = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	// request as handed from the front end to the back end
	typedef struct packed {
		logic              kind;
		logic              bad;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] time_ms;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0]   outcome;
		logic [SEQ_W-1:0]   next_expected;
		logic [DUP_W-1:0]   dup_count;
		logic [RTT_W-1:0]   rtt_estimate;
		logic [FREED_W-1:0] freed_count;
	} result_t;

endpackage

[rtl/core/caw_front.sv]
// Front end: takes requests, decodes the ASCII ack number and flags bad digits.
module caw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        kind,
	input  logic [caw_pkg::SEQ_W-1:0]   sent_seq,
	input  logic [caw_pkg::DIG_W-1:0]   ack_digits,
	input  logic [caw_pkg::TIME_W-1:0]  time_ms,
	input  logic                        q_full,
	output logic                        q_wr,
	output caw_pkg::item_t              q_item
);
	import caw_pkg::*;

	localparam int NDIG = DIG_W / 8;

	function automatic logic [16:0] dec_weight(input int pos);
		logic [16:0] w;
		case (pos)
			0: w = 17'd1;
			1: w = 17'd10;
			2: w = 17'd100;
			3: w = 17'd1000;
			4: w = 17'd10000;
			5: w = 17'd100000;
			default: w = 17'd0;
		endcase
		return w;
	endfunction

	logic             s1_valid_q;
	item_t            item_s1;
	item_t            item_d;
	logic             bad_any;
	logic [SEQ_W-1:0] ack_val;

	always_comb begin
		logic [7:0] b;
		bad_any = 1'b0;
		ack_val = '0;
		for (int i = 0; i < NDIG; i++) begin
			b = ack_digits[8*i +: 8];
			if (b < 8'd48 || b > 8'd57) begin
				bad_any = 1'b1;
			end
			ack_val = ack_val + ({16'b0, b[3:0]} * {3'b0, dec_weight(i)});
		end
	end

	always_comb begin
		item_d.kind    = kind;
		item_d.bad     = (kind == KIND_ACK) && bad_any;
		item_d.seq     = (kind == KIND_ACK) ? ack_val : sent_seq;
		item_d.time_ms = time_ms;
	end

	assign full   = s1_valid_q && q_full;
	assign q_wr   = s1_valid_q && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (push && !full) begin
			s1_valid_q <= 1'b1;
		end else if (q_wr) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_s1 <= item_d;
		end
	end

endmodule

[rtl/core/caw_fifo.sv]
// Short request queue between the front end and the back end.
module caw_fifo #(
	parameter int DEPTH = caw_pkg::QDEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  caw_pkg::item_t wr_item,
	output logic           full,
	input  logic           rd_en,
	output caw_pkg::item_t rd_item,
	output logic           empty
);
	import caw_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

[rtl/core/caw_back.sv]
// Back end: window state, slot walk, RTT smoothing and the result register.
module caw_back #(
	parameter int WINDOW = caw_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [caw_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [caw_pkg::CFG_W-1:0]      wr_data,
	input  logic                           q_empty,
	output logic                           q_rd,
	input  caw_pkg::item_t                 q_item,
	output logic                           res_valid,
	input  logic                           res_pop,
	output caw_pkg::result_t               res
);
	import caw_pkg::*;

	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int LEFT_W  = $clog2(WINDOW + 1);
	localparam int ACC_W   = 48;
	localparam int DSTEPS  = ACC_W / 8;
	localparam int DCNT_W  = $clog2(DSTEPS);

	localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW);
	localparam logic [SEQ_W-1:0] RECIP   = SEQ_W'((1 << SEQ_W) / WINDOW);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLASS = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_ACC   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]         state_q;
	item_t              item_q;
	logic [SEQ_W-1:0]   expected_q;
	logic [RTT_W-1:0]   rtt_q;
	logic [DUP_W-1:0]   dup_q;
	logic [WINDOW-1:0]  valid_q;
	logic [SEQ_W-1:0]   mod_val_q;
	logic [SEQ_W-1:0]   mod_quo_q;
	logic               mod_cnt_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [LEFT_W-1:0]  left_q;
	logic [FREED_W-1:0] freed_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   quo_q;
	logic [3:0]         rem_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [OUT_W-1:0]   outcome_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [TIME_W-1:0]  send_time_mem [WINDOW];
	logic [TIME_W-1:0]  rd_data_q;
	logic               mem_rd;
	logic               mem_wr;

	logic [SEQ_W:0]     diff;
	logic [2*SEQ_W-1:0] mod_prod;
	logic [2*SEQ_W-1:0] mod_back;
	logic [SEQ_W-1:0]   mod_rem;
	logic [SLOT_W-1:0]  mod_slot;
	logic [SLOT_W-1:0]  slot_inc;
	logic [TIME_W-1:0]  sample;
	logic [ACC_W-1:0]   acc_d;
	logic [3:0]         div_rem;
	logic [7:0]         div_bits;
	logic [ACC_W-1:0]   quo_full;
	logic [RTT_W-1:0]   rtt_new;

	assign q_rd      = (state_q == ST_IDLE) && !q_empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign diff = {1'b0, item_q.seq} - {1'b0, expected_q};

	// slot = value mod WINDOW: the reciprocal estimate of the quotient is low by at
	// most one, so a single compare and subtract finishes the remainder
	assign mod_prod = {{SEQ_W{1'b0}}, mod_val_q} * {{SEQ_W{1'b0}}, RECIP};
	assign mod_back = {{SEQ_W{1'b0}}, mod_quo_q} * {{SEQ_W{1'b0}}, WIN_SEQ};
	assign mod_rem  = mod_val_q - mod_back[SEQ_W-1:0];
	assign mod_slot = (mod_rem >= WIN_SEQ) ? SLOT_W'(mod_rem - WIN_SEQ) : SLOT_W'(mod_rem);

	assign slot_inc = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

	// 9*old + 256*sample + 5, so the divide by ten rounds half up
	assign sample = item_q.time_ms - rd_data_q;
	assign acc_d  = ({16'b0, rtt_q} << 3) + {16'b0, rtt_q} + {8'b0, sample, 8'b0}
		+ ACC_W'(5);

	// eight quotient bits of the divide by ten per cycle
	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		r = rem_q;
		div_bits = '0;
		for (int j = 7; j >= 0; j--) begin
			t = {r, acc_q[ACC_W-8+j]};
			if (t >= 5'd10) begin
				div_bits[j] = 1'b1;
				r = 4'(t - 5'd10);
			end else begin
				r = t[3:0];
			end
		end
		div_rem = r;
	end

	assign quo_full = {quo_q[ACC_W-9:0], div_bits};
	assign rtt_new  = (|quo_full[ACC_W-1:RTT_W]) ? '1 : quo_full[RTT_W-1:0];

	assign mem_rd = (state_q == ST_WALK) && (left_q != '0) && valid_q[slot_q];
	assign mem_wr = (state_q == ST_MOD) && mod_cnt_q && (item_q.kind == KIND_SEND);

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			send_time_mem[mod_slot] <= item_q.time_ms;
		end
		if (mem_rd) begin
			rd_data_q <= send_time_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			expected_q  <= '0;
			rtt_q       <= RTT_RESET;
			dup_q       <= '0;
			valid_q     <= '0;
			mod_val_q   <= '0;
			mod_quo_q   <= '0;
			mod_cnt_q   <= 1'b0;
			slot_q      <= '0;
			left_q      <= '0;
			freed_q     <= '0;
			acc_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			outcome_q   <= OUT_LATE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_pop && res_valid_q && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			if (wr_en) begin
				case (wr_index)
					REG_START_SEQ: begin
						expected_q <= wr_data[SEQ_W-1:0];
						dup_q      <= '0;
						valid_q    <= '0;
					end
					REG_INITIAL_RTT: begin
						rtt_q <= wr_data[RTT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						item_q  <= q_item;
						freed_q <= '0;
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					mod_val_q <= (item_q.kind == KIND_SEND) ? item_q.seq : expected_q;
					mod_cnt_q <= 1'b0;
					slot_q    <= '0;
					if (item_q.kind == KIND_SEND) begin
						if (!diff[SEQ_W] && diff[SEQ_W-1:0] < SEQ_W'(WINDOW)) begin
							state_q <= ST_MOD;
						end else begin
							outcome_q <= OUT_SEND_OUTSIDE;
							state_q   <= ST_DONE;
						end
					end else if (item_q.bad) begin
						outcome_q <= OUT_MALFORMED;
						state_q   <= ST_DONE;
					end else if (!diff[SEQ_W]) begin
						// clamp the walk to one full window
						if (diff[SEQ_W-1:0] >= SEQ_W'(WINDOW)) begin
							left_q <= LEFT_W'(WINDOW);
						end else begin
							left_q <= LEFT_W'(diff[SEQ_W-1:0] + 1'b1);
						end
						state_q <= ST_MOD;
					end else if (({1'b0, item_q.seq} + 1'b1) == {1'b0, expected_q}) begin
						if (dup_q != '1) begin
							dup_q <= dup_q + 1'b1;
						end
						outcome_q <= OUT_DUPLICATE;
						state_q   <= ST_DONE;
					end else begin
						outcome_q <= OUT_LATE;
						state_q   <= ST_DONE;
					end
				end
				ST_MOD: begin
					if (!mod_cnt_q) begin
						mod_quo_q <= mod_prod[2*SEQ_W-1:SEQ_W];
						mod_cnt_q <= 1'b1;
					end else begin
						slot_q    <= mod_slot;
						mod_cnt_q <= 1'b0;
						if (item_q.kind == KIND_SEND) begin
							valid_q[mod_slot] <= 1'b1;
							outcome_q         <= OUT_RECORDED;
							state_q           <= ST_DONE;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (left_q == '0) begin
						expected_q <= SEQ_W'({1'b0, item_q.seq} + 1'b1);
						dup_q      <= '0;
						outcome_q  <= OUT_ADVANCED;
						state_q    <= ST_DONE;
					end else if (valid_q[slot_q]) begin
						valid_q[slot_q] <= 1'b0;
						state_q         <= ST_ACC;
					end else begin
						slot_q <= slot_inc;
						left_q <= left_q - 1'b1;
					end
				end
				ST_ACC: begin
					acc_q     <= acc_d;
					quo_q     <= '0;
					rem_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					acc_q     <= acc_q << 8;
					quo_q     <= quo_full;
					rem_q     <= div_rem;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCNT_W'(DSTEPS - 1)) begin
						rtt_q  <= rtt_new;
						slot_q <= slot_inc;
						left_q <= left_q - 1'b1;
						if (freed_q != '1) begin
							freed_q <= freed_q + 1'b1;
						end
						state_q <= ST_WALK;
					end
				end
				ST_DONE: begin
					// hold until the result register is free
					if (!res_valid_q || res_pop) begin
						res_q.outcome       <= outcome_q;
						res_q.next_expected <= expected_q;
						res_q.dup_count     <= dup_q;
						res_q.rtt_estimate  <= rtt_q;
						res_q.freed_count   <= freed_q;
						res_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/cumulative_ack_window_rtt.sv]
// Top level of the cumulative acknowledgement engine with smoothed RTT estimate.
// Requests enter through a push/full queue port and results leave through an
// empty/pop queue port; a front end decodes each request into a short queue and
// the back end executes one request at a time. A send record passes through the
// reciprocal modulo-WINDOW slot reduction in the back end; a send outside the
// window, and a duplicate, late or malformed ack, skip it. An advancing ack walks
// the slots from the expected number up to the acked one, at most one window;
// each freed packet costs one send-time memory read, one accumulate and a pass
// through the divide-by-ten unit. A result that is not popped holds the back end
// in its done state with the next result. Writing start_seq clears the window at
// once; there is no clearing pass after reset.
module cumulative_ack_window_rtt #(
	parameter int WINDOW = caw_pkg::WINDOW_DEF,
	parameter int QDEPTH = caw_pkg::QDEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           kind,
	input  logic [caw_pkg::SEQ_W-1:0]      sent_seq,
	input  logic [caw_pkg::DIG_W-1:0]      ack_digits,
	input  logic [caw_pkg::TIME_W-1:0]     time_ms,
	output logic                           empty,
	input  logic                           pop,
	output logic [caw_pkg::OUT_W-1:0]      outcome,
	output logic [caw_pkg::SEQ_W-1:0]      next_expected,
	output logic [caw_pkg::DUP_W-1:0]      dup_count,
	output logic [caw_pkg::RTT_W-1:0]      rtt_estimate,
	output logic [caw_pkg::FREED_W-1:0]    freed_count,
	input  logic                           wr_en,
	input  logic [caw_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [caw_pkg::CFG_W-1:0]      wr_data
);
	import caw_pkg::*;

	logic    q_wr;
	logic    q_full;
	logic    q_rd;
	logic    q_empty;
	item_t   q_wr_item;
	item_t   q_rd_item;
	logic    res_valid;
	result_t res;

	caw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.sent_seq   (sent_seq),
		.ack_digits (ack_digits),
		.time_ms    (time_ms),
		.q_full     (q_full),
		.q_wr       (q_wr),
		.q_item     (q_wr_item)
	);

	caw_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	caw_back #(.WINDOW(WINDOW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.q_item    (q_rd_item),
		.res_valid (res_valid),
		.res_pop   (pop),
		.res       (res)
	);

	assign empty         = !res_valid;
	assign outcome       = res.outcome;
	assign next_expected = res.next_expected;
	assign dup_count     = res.dup_count;
	assign rtt_estimate  = res.rtt_estimate;
	assign freed_count   = res.freed_count;

	// only an advancing ack releases packets
	a_freed_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && freed_count != '0) |-> (outcome == OUT_ADVANCED))
		else $error("packets freed by a non-advancing result");

	// an advancing ack restarts the duplicate run
	a_dup_cleared_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && outcome == OUT_ADVANCED) |-> (dup_count == '0))
		else $error("duplicate count left standing after an advance");

	// the queue is only written when the front stage holds a request
	a_front_full_needs_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("front end stalled with room in the queue");

	// a result is only produced by the back end after it took a request
	a_result_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(res_valid)) |-> $past(!q_rd))
		else $error("result appeared in the cycle after a queue read");

endmodule

[verif/caw_checker.sv]
`timescale 1ns / 1ps
// Checker for the ack engine: tracks requests and register writes, predicts and compares results.
module caw_checker #(
	parameter int WINDOW = caw_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic                          kind,
	input  logic [caw_pkg::SEQ_W-1:0]     sent_seq,
	input  logic [caw_pkg::DIG_W-1:0]     ack_digits,
	input  logic [caw_pkg::TIME_W-1:0]    time_ms,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [caw_pkg::OUT_W-1:0]     outcome,
	input  logic [caw_pkg::SEQ_W-1:0]     next_expected,
	input  logic [caw_pkg::DUP_W-1:0]     dup_count,
	input  logic [caw_pkg::RTT_W-1:0]     rtt_estimate,
	input  logic [caw_pkg::FREED_W-1:0]   freed_count,
	input  logic                          wr_en,
	input  logic [caw_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [caw_pkg::CFG_W-1:0]     wr_data,
	output int                            errors,
	output int                            checked
);
	import caw_pkg::*;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [DUP_W-1:0] DUP_MAX = '1;
	localparam int FREED_MAX = (1 << FREED_W) - 1;

	logic [SEQ_W-1:0]  want_seq;
	logic [RTT_W-1:0]  rtt_now;
	logic [DUP_W-1:0]  dup_run;
	logic [TIME_W-1:0] send_stamp [WINDOW];
	bit                slot_busy  [WINDOW];
	result_t           result_q   [$];

	// rtt = (9*rtt + 256*sample) / 10, round half up, clamp to 32 bits
	function automatic logic [RTT_W-1:0] ewma_step(logic [RTT_W-1:0] old,
			logic [TIME_W-1:0] sample);
		logic [63:0] acc;
		acc = {32'd0, old} * 64'd9 + ({32'd0, sample} << 8);
		acc = (acc + 64'd5) / 64'd10;
		return (acc > 64'hFFFF_FFFF) ? '1 : acc[RTT_W-1:0];
	endfunction

	function automatic result_t ack_engine_step(logic k, logic [SEQ_W-1:0] seq,
			logic [DIG_W-1:0] dig, logic [TIME_W-1:0] now);
		result_t r;
		logic [7:0] ch;
		int unsigned ack_val, span, slot, freed, exp_val;
		bit bad;
		freed = 0;
		exp_val = want_seq;
		if (k == KIND_SEND) begin
			if (seq >= exp_val && seq - exp_val < WINDOW) begin
				slot = seq % WINDOW;
				send_stamp[slot] = now;
				slot_busy[slot] = 1'b1;
				r.outcome = OUT_RECORDED;
			end else begin
				r.outcome = OUT_SEND_OUTSIDE;
			end
		end else begin
			ack_val = 0;
			bad = 1'b0;
			for (int i = 5; i >= 0; i--) begin
				ch = dig[8*i +: 8];
				if (ch < ASCII_ZERO || ch > ASCII_NINE) bad = 1'b1;
				else ack_val = ack_val * 10 + (ch - ASCII_ZERO);
			end
			if (bad) begin
				r.outcome = OUT_MALFORMED;
			end else if (ack_val >= exp_val) begin
				// walk at most one window; that covers every outstanding packet
				span = ack_val - exp_val + 1;
				if (span > WINDOW) span = WINDOW;
				for (int unsigned j = 0; j < span; j++) begin
					slot = (exp_val + j) % WINDOW;
					if (slot_busy[slot]) begin
						slot_busy[slot] = 1'b0;
						rtt_now = ewma_step(rtt_now, now - send_stamp[slot]);
						freed++;
					end
				end
				want_seq = SEQ_W'(ack_val + 1);
				dup_run = '0;
				r.outcome = OUT_ADVANCED;
			end else if (ack_val + 1 == exp_val) begin
				if (dup_run != DUP_MAX) dup_run++;
				r.outcome = OUT_DUPLICATE;
			end else begin
				r.outcome = OUT_LATE;
			end
		end
		if (freed > FREED_MAX) freed = FREED_MAX;
		r.next_expected = want_seq;
		r.dup_count = dup_run;
		r.rtt_estimate = rtt_now;
		r.freed_count = FREED_W'(freed);
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got,
			inout int miss);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			miss++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		int miss;
		if (!arst_n) begin
			want_seq = '0;
			rtt_now = RTT_RESET;
			dup_run = '0;
			foreach (slot_busy[i]) slot_busy[i] = 1'b0;
			result_q.delete();
			errors <= 0;
			checked <= 0;
		end else begin
			miss = 0;
			if (wr_en) begin
				if (wr_index == REG_START_SEQ) begin
					want_seq = wr_data[SEQ_W-1:0];
					dup_run = '0;
					foreach (slot_busy[i]) slot_busy[i] = 1'b0;
				end else if (wr_index == REG_INITIAL_RTT) begin
					rtt_now = wr_data[RTT_W-1:0];
				end
			end
			if (push && !full)
				result_q.push_back(ack_engine_step(kind, sent_seq, ack_digits, time_ms));
			if (pop && !empty) begin
				if (result_q.size() == 0) begin
					$display("%0t ns: result with none expected, expected nothing actual outcome %0d",
						$time, outcome);
					miss++;
				end else begin
					want = result_q.pop_front();
					check_field("outcome", want.outcome, outcome, miss);
					check_field("next_expected", want.next_expected, next_expected, miss);
					check_field("dup_count", want.dup_count, dup_count, miss);
					check_field("rtt_estimate", want.rtt_estimate, rtt_estimate, miss);
					check_field("freed_count", want.freed_count, freed_count, miss);
					checked <= checked + 1;
				end
			end
			if (miss != 0) errors <= errors + miss;
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, request and register stimulus, and the verdict.
module tb_top;
	import caw_pkg::*;

	localparam int WINDOW = WINDOW_DEF;
	localparam int MAX_CYCLES = 1_500_000;
	localparam int unsigned SEQ_TOP = 999_999;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_COLON = 8'h3A;
	localparam logic [7:0] ASCII_SLASH = 8'h2F;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 kind;
	logic [SEQ_W-1:0]     sent_seq;
	logic [DIG_W-1:0]     ack_digits;
	logic [TIME_W-1:0]    time_ms;
	logic                 empty;
	logic                 pop;
	logic [OUT_W-1:0]     outcome;
	logic [SEQ_W-1:0]     next_expected;
	logic [DUP_W-1:0]     dup_count;
	logic [RTT_W-1:0]     rtt_estimate;
	logic [FREED_W-1:0]   freed_count;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	int                errors;
	int                checked;
	int                cycles = 0;
	int unsigned       sent_total = 0;
	int unsigned       settings = 1;
	int unsigned       lo = 0;
	int unsigned       hi = 0;
	logic [TIME_W-1:0] clock_ms = '0;
	bit                calm = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	cumulative_ack_window_rtt #(.WINDOW(WINDOW)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.kind(kind), .sent_seq(sent_seq), .ack_digits(ack_digits), .time_ms(time_ms),
		.empty(empty), .pop(pop),
		.outcome(outcome), .next_expected(next_expected), .dup_count(dup_count),
		.rtt_estimate(rtt_estimate), .freed_count(freed_count),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	caw_checker #(.WINDOW(WINDOW)) i_check (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.kind(kind), .sent_seq(sent_seq), .ack_digits(ack_digits), .time_ms(time_ms),
		.empty(empty), .pop(pop),
		.outcome(outcome), .next_expected(next_expected), .dup_count(dup_count),
		.rtt_estimate(rtt_estimate), .freed_count(freed_count),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.errors(errors), .checked(checked)
	);

	function automatic logic [DIG_W-1:0] ascii_number(int unsigned v);
		logic [DIG_W-1:0] d;
		for (int i = 0; i < 6; i++) begin
			d[8*i +: 8] = ASCII_ZERO + 8'(v % 10);
			v = v / 10;
		end
		return d;
	endfunction

	function automatic logic [DIG_W-1:0] rand_digits();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[DIG_W-1:0];
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic issue(logic k, logic [SEQ_W-1:0] seq, logic [DIG_W-1:0] dig,
			logic [TIME_W-1:0] now);
		int unsigned gap;
		kind <= k;
		sent_seq <= seq;
		ack_digits <= dig;
		time_ms <= now;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		sent_total++;
		gap = pick_gap(calm);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold until every request has its result back
	task automatic settle();
		push <= 1'b0;
		while (checked != sent_total) @(posedge clk);
	endtask

	task automatic write_regs(logic [CFG_W-1:0] seq, logic [CFG_W-1:0] rtt);
		wr_en <= 1'b1;
		wr_index <= REG_START_SEQ;
		wr_data <= seq;
		@(posedge clk);
		wr_index <= REG_INITIAL_RTT;
		wr_data <= rtt;
		@(posedge clk);
		wr_en <= 1'b0;
		lo = seq;
		hi = seq;
	endtask

	task automatic random_request();
		int unsigned r, a;
		r = $urandom_range(0, 99);
		clock_ms += $urandom_range(0, 40);
		if (r < 45 && hi - lo < WINDOW) begin
			// skip a number now and then so the walk meets empty slots
			if (hi - lo < WINDOW - 1 && $urandom_range(0, 3) == 0) hi++;
			issue(KIND_SEND, SEQ_W'(hi), rand_digits(), clock_ms);
			hi++;
		end else if (r < 75) begin
			if ($urandom_range(0, 9) == 0) a = hi + $urandom_range(0, 5000);
			else if (hi > lo) a = lo + $urandom_range(0, hi - lo - 1);
			else a = lo;
			if (a > SEQ_TOP) a = SEQ_TOP;
			issue(KIND_ACK, SEQ_W'($urandom), ascii_number(a), clock_ms);
			if (a >= lo) begin
				lo = a + 1;
				if (hi < lo) hi = lo;
			end
		end else if (r < 83 && lo > 0) begin
			issue(KIND_ACK, SEQ_W'($urandom), ascii_number(lo - 1), clock_ms);
		end else if (r < 88 && lo > 1) begin
			issue(KIND_ACK, SEQ_W'($urandom), ascii_number($urandom_range(0, lo - 2)),
				clock_ms);
		end else if (r < 92 && hi > lo) begin
			issue(KIND_SEND, SEQ_W'(lo + $urandom_range(0, hi - lo - 1)), rand_digits(),
				clock_ms);
		end else if (r < 96) begin
			issue(KIND_ACK, SEQ_W'($urandom), rand_digits(), $urandom);
		end else begin
			issue(KIND_SEND, SEQ_W'($urandom), rand_digits(), $urandom);
		end
	endtask

	task automatic random_phase(logic [CFG_W-1:0] first_seq, logic [CFG_W-1:0] first_rtt,
			int unsigned dup_burst, int unsigned count, logic [TIME_W-1:0] clock_start,
			bit quiet);
		settle();
		write_regs(first_seq, first_rtt);
		settings++;
		clock_ms = clock_start;
		calm = quiet;
		repeat (dup_burst) issue(KIND_ACK, SEQ_W'($urandom), ascii_number(lo - 1), clock_ms);
		repeat (count) random_request();
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d of %0d results seen",
				cycles, checked, sent_total);
			$display("** cumulative_ack_window_rtt: FAILED **");
			$finish;
		end
	end

	initial begin : result_side
		int unsigned hold;
		hold = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= 1'b1;
				hold = pick_gap(calm);
			end
		end
	end

	initial begin : request_side
		logic [DIG_W-1:0] odd;
		arst_n <= 1'b0;
		push <= 1'b0;
		kind <= KIND_SEND;
		sent_seq <= '0;
		ack_digits <= '0;
		time_ms <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_START_SEQ;
		wr_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window starts at zero
		issue(KIND_SEND, 20'd0, '0, 32'd100);
		issue(KIND_SEND, 20'd63, '1, 32'd110);
		issue(KIND_SEND, 20'd64, '0, 32'd120);
		issue(KIND_SEND, '1, '1, 32'hFFFF_FFFF);
		issue(KIND_SEND, 20'd0, '0, 32'd150);   // resend overwrites the send time
		odd = ascii_number(5);
		odd[23:16] = ASCII_COLON;
		issue(KIND_ACK, '0, odd, 32'd160);
		odd = ascii_number(5);
		odd[47:40] = ASCII_SLASH;
		issue(KIND_ACK, '1, odd, 32'd160);
		issue(KIND_ACK, '0, '1, '1);
		issue(KIND_ACK, '1, '0, '0);
		issue(KIND_ACK, '0, ascii_number(0), 32'd200);   // ack of zero advances
		issue(KIND_ACK, '0, ascii_number(0), 32'd201);
		issue(KIND_ACK, '0, ascii_number(0), 32'd202);
		issue(KIND_SEND, 20'd1, '0, 32'd300);
		issue(KIND_SEND, 20'd2, '0, 32'd305);
		issue(KIND_ACK, '0, ascii_number(2), 32'd400);
		issue(KIND_ACK, '0, ascii_number(0), 32'd401);
		// far ack with a wrapped clock: sample near 2^32 drives the estimate to its ceiling
		issue(KIND_ACK, '0, ascii_number(SEQ_TOP), 32'd5);
		issue(KIND_ACK, '0, ascii_number(SEQ_TOP), 32'd6);
		issue(KIND_SEND, 20'd999_999, '0, 32'd7);
		issue(KIND_SEND, 20'd1_000_000, '0, 32'd10);
		issue(KIND_SEND, 20'd1_000_063, '0, 32'd20);
		issue(KIND_ACK, '0, ascii_number(SEQ_TOP), 32'd30);

		random_phase(32'd0, 32'd0, 0, 40, 32'd0, 1'b0);
		random_phase(32'd999_999, 32'hFFFF_FFFF, 0, 20, 32'd1000, 1'b0);
		random_phase(32'd1234, 32'd25600, 260, 20, 32'd50, 1'b0);   // duplicate count saturates
		random_phase($urandom_range(0, 990_000), $urandom, 0, 50, 32'hFFFF_FF00, 1'b1);
		random_phase(32'd999_900, 32'd100, 0, 40, $urandom, 1'b0);

		settle();
		calm = 1'b0;
		repeat (40) @(posedge clk);
		$display("covered %0d requests over %0d register settings; %0d results compared",
			sent_total, settings, checked);
		$display("sends, advancing/duplicate/late/malformed acks, far acks, clock wrap, %0d mismatches",
			errors);
		if (errors == 0)
			$display("** cumulative_ack_window_rtt: PASSED **");
		else
			$display("** cumulative_ack_window_rtt: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/caw_pkg.sv
rtl/core/caw_front.sv
rtl/core/caw_fifo.sv
rtl/core/caw_back.sv
rtl/core/cumulative_ack_window_rtt.sv
verif/caw_checker.sv
verif/tb_top.sv
